// ===== hw/rtl/swod_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding-window outlier detector package
// Shared widths, register reset values, register indexes and control types.
// ----------------------------------------------------------------------------
package swod_pkg;

    localparam int WINDOW_MAX_DEF = 64;

    localparam int SAMPLE_W = 16;
    localparam int MEAN_W   = 24;
    localparam int STD_W    = 24;
    localparam int LEN_W    = 7;
    localparam int THR_W    = 12;
    localparam int KEY_W    = SAMPLE_W + 3;

    localparam logic [LEN_W-1:0] WINDOW_LENGTH_RST = 7'd64;
    localparam logic [THR_W-1:0] Z_THR_RST         = 12'd768;
    localparam logic [THR_W-1:0] MODZ_THR_RST      = 12'd896;
    localparam logic [THR_W-1:0] IQR_MULT_RST      = 12'd384;

    localparam int MODZ_W = 16;
    localparam logic [MODZ_W-1:0] MODZ_CONST = 16'd44204;
    localparam int IQR_MIN_COUNT = 4;
    localparam int STAT_MIN_COUNT = 2;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_WINDOW_LENGTH,
        REG_Z_THRESHOLD,
        REG_MODZ_THRESHOLD,
        REG_IQR_MULT
    } t_reg_idx;

    typedef enum logic {
        SEL_VALUE,
        SEL_DEVIATION
    } t_key_sel;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } t_arith_op;

    typedef struct packed {
        logic      start;
        t_arith_op op;
    } t_arith_ctl;

    typedef struct packed {
        logic     start;
        t_key_sel sel;
    } t_rank_ctl;

endpackage

// ===== hw/rtl/swod_if.sv =====
// ----------------------------------------------------------------------------
// Sliding-window outlier detector channels
// Sample input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface swod_in_if;
    import swod_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface swod_out_if;
    import swod_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [MEAN_W-1:0] mean_q8;
    logic [STD_W-1:0]         std_dev_q8;
    logic                     z_outlier;
    logic                     mod_z_outlier;
    logic                     iqr_outlier;
    logic [LEN_W-1:0]         sample_count;

    modport source (
        output valid, output mean_q8, output std_dev_q8, output z_outlier,
        output mod_z_outlier, output iqr_outlier, output sample_count,
        input ready
    );
    modport sink (
        input valid, input mean_q8, input std_dev_q8, input z_outlier,
        input mod_z_outlier, input iqr_outlier, input sample_count,
        output ready
    );
endinterface

// ===== hw/rtl/swod_arith.sv =====
// ----------------------------------------------------------------------------
// Shift-subtract unit
// Restoring divider (one quotient bit per cycle) and integer square root
// (one root bit per cycle) sharing one shift register and counter.
// ----------------------------------------------------------------------------
module swod_arith #(
    parameter int NUM_W = 62,
    parameter int DEN_W = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  swod_pkg::t_arith_ctl  i_ctl,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [DEN_W-1:0]      i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_result
);
    import swod_pkg::*;

    localparam int RT_W  = NUM_W / 2;
    localparam int SR_W  = RT_W + 2;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              r_busy;
    t_arith_op         r_op;
    logic [CNT_W-1:0]  r_cnt;
    logic [NUM_W-1:0]  r_acc;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [RT_W-1:0]   r_root;
    logic [SR_W-1:0]   r_srem;
    logic              r_done;

    logic [DEN_W:0]    div_sh;
    logic              div_ge;
    logic [DEN_W:0]    div_diff;
    logic [SR_W+1:0]   sq_sh;
    logic [SR_W+1:0]   sq_trial;
    logic              sq_ge;
    logic [SR_W+1:0]   sq_diff;

    always_comb begin
        div_sh   = {r_rem, r_acc[NUM_W-1]};
        div_ge   = (div_sh >= {1'b0, r_den});
        div_diff = div_sh - {1'b0, r_den};
        sq_sh    = {r_srem, r_acc[NUM_W-1 -: 2]};
        sq_trial = {2'b00, r_root, 2'b01};
        sq_ge    = (sq_sh >= sq_trial);
        sq_diff  = sq_sh - sq_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_DIV;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_op   <= i_ctl.op;
                r_acc  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_srem <= '0;
                r_root <= '0;
                r_cnt  <= (i_ctl.op == OP_DIV) ? CNT_W'(NUM_W) : CNT_W'(RT_W);
            end else if (r_busy) begin
                if (r_op == OP_DIV) begin
                    r_rem <= div_ge ? div_diff[DEN_W-1:0] : div_sh[DEN_W-1:0];
                    r_acc <= {r_acc[NUM_W-2:0], div_ge};
                end else begin
                    r_srem <= sq_ge ? sq_diff[SR_W-1:0] : sq_sh[SR_W-1:0];
                    r_root <= {r_root[RT_W-2:0], sq_ge};
                    r_acc  <= {r_acc[NUM_W-3:0], 2'b00};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = (r_op == OP_DIV) ? r_acc : {{(NUM_W-RT_W){1'b0}}, r_root};

endmodule

// ===== hw/rtl/swod_rank.sv =====
// ----------------------------------------------------------------------------
// Window store and rank selector
// Holds the sample window and finds order statistics by counting, for each
// entry, the entries that sort ahead of it (one compare per cycle).
// ----------------------------------------------------------------------------
module swod_rank #(
    parameter int WINDOW_MAX = 64,
    parameter int CW         = 7,
    parameter int AW         = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [AW-1:0]                       i_wr_addr,
    input  logic signed [swod_pkg::SAMPLE_W-1:0] i_wr_data,
    input  logic [AW-1:0]                       i_rd_addr,
    output logic signed [swod_pkg::SAMPLE_W-1:0] o_rd_data,
    input  swod_pkg::t_rank_ctl                 i_ctl,
    input  logic signed [swod_pkg::SAMPLE_W:0]   i_med2,
    input  logic [CW-1:0]                       i_count,
    output logic                                o_done,
    output logic signed [swod_pkg::KEY_W-1:0]    o_lo,
    output logic signed [swod_pkg::KEY_W-1:0]    o_hi,
    output logic signed [swod_pkg::KEY_W-1:0]    o_q1,
    output logic signed [swod_pkg::KEY_W-1:0]    o_q3
);
    import swod_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_KEY,
        ST_SCAN,
        ST_RANK
    } t_state;

    logic signed [SAMPLE_W-1:0] r_mem [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] r_rd;

    t_state                  r_state;
    t_key_sel                r_sel;
    logic signed [SAMPLE_W:0] r_m2;
    logic [CW-1:0]           r_n;
    logic [CW-1:0]           r_i;
    logic [CW-1:0]           r_j;
    logic [CW-1:0]           r_pj;
    logic                    r_pv;
    logic [CW-1:0]           r_cnt;
    logic signed [KEY_W-1:0] r_ki;
    logic signed [KEY_W-1:0] r_lo;
    logic signed [KEY_W-1:0] r_hi;
    logic signed [KEY_W-1:0] r_q1;
    logic signed [KEY_W-1:0] r_q3;
    logic                    r_done;

    logic [AW-1:0]           rd_addr;
    logic signed [KEY_W-1:0] key_j;
    logic                    ahead;
    logic [CW-1:0]           k_hi;
    logic [CW-1:0]           k_lo;
    logic [CW-1:0]           k_q1;
    logic [CW+1:0]           n3;
    logic [CW-1:0]           k_q3;

    function automatic logic signed [KEY_W-1:0] f_key(
        input logic signed [SAMPLE_W-1:0] v,
        input t_key_sel                   sel,
        input logic signed [SAMPLE_W:0]   m2
    );
        logic signed [SAMPLE_W+1:0] t;
        logic [SAMPLE_W+1:0]        a;
        t = $signed({v[SAMPLE_W-1], v, 1'b0}) - $signed({m2[SAMPLE_W], m2});
        a = t[SAMPLE_W+1] ? $unsigned(-t) : $unsigned(t);
        if (sel == SEL_VALUE) begin
            return {{(KEY_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
        end
        return $signed({1'b0, a});
    endfunction

    always_comb begin
        case (r_state)
            ST_LOAD: rd_addr = r_i[AW-1:0];
            ST_SCAN: rd_addr = r_j[AW-1:0];
            default: rd_addr = i_rd_addr;
        endcase
        key_j = f_key(r_rd, r_sel, r_m2);
        ahead = (key_j < r_ki) || ((key_j == r_ki) && (r_pj < r_i));
        k_hi  = r_n >> 1;
        k_lo  = r_n[0] ? k_hi : k_hi - 1'b1;
        k_q1  = r_n >> 2;
        n3    = {2'b00, r_n} + {1'b0, r_n, 1'b0};
        k_q3  = n3[CW+1:2];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_ctl.start) begin
                        r_sel   <= i_ctl.sel;
                        r_m2    <= i_med2;
                        r_n     <= i_count;
                        r_i     <= '0;
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_state <= ST_KEY;
                end
                ST_KEY: begin
                    r_ki    <= key_j;
                    r_j     <= '0;
                    r_cnt   <= '0;
                    r_pv    <= 1'b0;
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (r_pv && ahead) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_j < r_n) begin
                        r_pv <= 1'b1;
                        r_pj <= r_j;
                        r_j  <= r_j + 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_state <= ST_RANK;
                        end
                    end
                end
                ST_RANK: begin
                    if (r_cnt == k_lo) r_lo <= r_ki;
                    if (r_cnt == k_hi) r_hi <= r_ki;
                    if (r_cnt == k_q1) r_q1 <= r_ki;
                    if (r_cnt == k_q3) r_q3 <= r_ki;
                    if (r_i == r_n - 1'b1) begin
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_LOAD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_rd_data = r_rd;
    assign o_done    = r_done;
    assign o_lo      = r_lo;
    assign o_hi      = r_hi;
    assign o_q1      = r_q1;
    assign o_q3      = r_q3;

endmodule

// ===== hw/rtl/sliding_window_outlier_detector.sv =====
// ----------------------------------------------------------------------------
// Sliding-window outlier detector
// Running mean and standard deviation of a sample window with z-score,
// modified z-score and interquartile-range outlier flags on each new sample.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on i_smp (valid/ready); one result word leaves on o_res per
//   sample. The block works on one sample at a time: i_smp.ready is high only
//   when idle, and o_res.valid holds until the receiver takes the word; a
//   stalled receiver simply keeps the block from taking the next sample.
//   Registers are to be written over the APB port only while idle (the block
//   does not enforce this); writing window_length empties the window.
//   With n < 2 samples held, only the mean divide runs. With n >= 2, the
//   shift-subtract unit does the mean and variance divides and the square
//   root, and two rank passes run over the window store (one compare a
//   cycle, one read port).
//   Reset restores register defaults and empties the window; the window
//   store itself is not cleared, as only held entries are ever read.
// ----------------------------------------------------------------------------
module sliding_window_outlier_detector #(
    parameter int WINDOW_MAX = swod_pkg::WINDOW_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    swod_in_if.sink                           i_smp,
    swod_out_if.source                        o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swod_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [swod_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [swod_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import swod_pkg::*;

    localparam int CW      = $clog2(WINDOW_MAX + 1);
    localparam int AW      = $clog2(WINDOW_MAX);
    localparam int SUM_W   = SAMPLE_W + CW;
    localparam int SQ_W    = 2 * SAMPLE_W - 1 + CW;
    localparam int P_W     = CW + SQ_W;
    localparam int S2_W    = 2 * SUM_W;
    localparam int D_W     = (P_W > S2_W) ? P_W : S2_W;
    localparam int NUM_RAW = D_W + 16;
    localparam int NUM_W   = NUM_RAW + (NUM_RAW % 2);
    localparam int RT_W    = NUM_W / 2;
    localparam int DEN_W   = 2 * CW;
    localparam int MF_W    = SUM_W + 9;
    localparam int DZ_W    = MF_W + 1;
    localparam int IQ_W    = 32;
    localparam int CMP_W   = 64;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDOLD,
        S_UPD,
        S_PROD1,
        S_MEAN,
        S_VAR,
        S_VWAIT,
        S_SQRT,
        S_SWAIT,
        S_RK0,
        S_RK0W,
        S_RK1,
        S_RK1W,
        S_PROD2,
        S_FLAG,
        S_OUT
    } t_state;

    t_state                     r_state;
    logic [LEN_W-1:0]           r_len;
    logic [THR_W-1:0]           r_zt;
    logic [THR_W-1:0]           r_mzt;
    logic [THR_W-1:0]           r_im;
    logic [AW-1:0]              r_slot;
    logic [CW-1:0]              r_held;
    logic signed [SUM_W-1:0]    r_sum;
    logic [SQ_W-1:0]            r_sq;
    logic signed [SAMPLE_W-1:0] r_x;
    logic [P_W-1:0]             r_nsq;
    logic [S2_W-1:0]            r_s2;
    logic [DEN_W-1:0]           r_nn;
    logic signed [MF_W-1:0]     r_mean;
    logic [STD_W-1:0]           r_std;
    logic signed [SAMPLE_W:0]   r_med2;
    logic signed [SAMPLE_W-1:0] r_q1;
    logic signed [SAMPLE_W-1:0] r_q3;
    logic [KEY_W-1:0]           r_mad4;
    logic [DZ_W+7:0]            r_zl;
    logic [THR_W+STD_W-1:0]     r_zr;
    logic [KEY_W+MODZ_W-1:0]    r_ml;
    logic [THR_W+KEY_W-1:0]     r_mr;
    logic [THR_W+SAMPLE_W:0]    r_span;
    logic                       r_zf;
    logic                       r_mzf;
    logic                       r_iqf;

    logic [CW-1:0]              eff_len;
    logic                       full;
    logic                       cfg_wr;
    t_reg_idx                   cfg_idx;
    logic signed [SAMPLE_W-1:0] old_val;
    logic signed [2*SAMPLE_W-1:0] x_sq;
    logic signed [2*SAMPLE_W-1:0] old_sq;
    logic [SUM_W-1:0]           sum_mag;
    logic signed [D_W:0]        d_diff;
    logic [D_W-1:0]             dd;
    logic signed [DZ_W-1:0]     dz;
    logic [DZ_W-1:0]            dz_abs;
    logic signed [SAMPLE_W+1:0] t4;
    logic [SAMPLE_W+1:0]        t4_abs;
    logic [KEY_W-1:0]           dev4;
    logic [SAMPLE_W:0]          q_span;
    logic signed [IQ_W-1:0]     x8;
    logic signed [IQ_W-1:0]     lo_fence;
    logic signed [IQ_W-1:0]     hi_fence;
    logic [RT_W-1:0]            root;

    t_arith_ctl                 arith_ctl;
    logic [NUM_W-1:0]           arith_num;
    logic [DEN_W-1:0]           arith_den;
    logic                       arith_done;
    logic [NUM_W-1:0]           arith_res;

    t_rank_ctl                  rank_ctl;
    logic                       rank_done;
    logic signed [KEY_W-1:0]    rank_lo;
    logic signed [KEY_W-1:0]    rank_hi;
    logic signed [KEY_W-1:0]    rank_q1;
    logic signed [KEY_W-1:0]    rank_q3;

    always_comb begin
        if (r_len == '0) begin
            eff_len = CW'(1);
        end else if ({25'd0, r_len} > 32'(WINDOW_MAX)) begin
            eff_len = CW'(WINDOW_MAX);
        end else begin
            eff_len = CW'(r_len);
        end
        full    = (r_held >= eff_len);
        cfg_wr  = psel && penable && pwrite && pready;
        cfg_idx = t_reg_idx'(paddr[3:2]);

        x_sq    = r_x * r_x;
        old_sq  = old_val * old_val;
        sum_mag = r_sum[SUM_W-1] ? $unsigned(-r_sum) : $unsigned(r_sum);
        d_diff  = $signed({1'b0, D_W'(r_nsq)}) - $signed({1'b0, D_W'(r_s2)});
        dd      = d_diff[D_W] ? '0 : d_diff[D_W-1:0];
        root    = arith_res[RT_W-1:0];

        dz      = DZ_W'($signed({r_x, 8'd0})) - DZ_W'(r_mean);
        dz_abs  = dz[DZ_W-1] ? $unsigned(-dz) : $unsigned(dz);
        t4      = $signed({r_x[SAMPLE_W-1], r_x, 1'b0}) - $signed({r_med2[SAMPLE_W], r_med2});
        t4_abs  = t4[SAMPLE_W+1] ? $unsigned(-t4) : $unsigned(t4);
        dev4    = {t4_abs, 1'b0};
        q_span  = $unsigned($signed({r_q3[SAMPLE_W-1], r_q3})
                            - $signed({r_q1[SAMPLE_W-1], r_q1}));
        x8       = IQ_W'($signed({r_x, 8'd0}));
        lo_fence = IQ_W'($signed({r_q1, 8'd0})) - $signed(IQ_W'(r_span));
        hi_fence = IQ_W'($signed({r_q3, 8'd0})) + $signed(IQ_W'(r_span));

        arith_ctl.start = (r_state == S_PROD1) || (r_state == S_VAR) || (r_state == S_SQRT);
        arith_ctl.op    = (r_state == S_SQRT) ? OP_SQRT : OP_DIV;
        case (r_state)
            S_PROD1: begin
                arith_num = NUM_W'({sum_mag, 8'd0});
                arith_den = DEN_W'(r_held);
            end
            S_SQRT: begin
                arith_num = arith_res;
                arith_den = r_nn;
            end
            default: begin
                arith_num = NUM_W'({dd, 16'd0});
                arith_den = r_nn;
            end
        endcase

        rank_ctl.start = (r_state == S_RK0) || (r_state == S_RK1);
        rank_ctl.sel   = (r_state == S_RK1) ? SEL_DEVIATION : SEL_VALUE;

        case (cfg_idx)
            REG_WINDOW_LENGTH:  prdata = APB_DATA_W'(r_len);
            REG_Z_THRESHOLD:    prdata = APB_DATA_W'(r_zt);
            REG_MODZ_THRESHOLD: prdata = APB_DATA_W'(r_mzt);
            REG_IQR_MULT:       prdata = APB_DATA_W'(r_im);
            default:            prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    swod_arith #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (arith_ctl),
        .i_num    (arith_num),
        .i_den    (arith_den),
        .o_done   (arith_done),
        .o_result (arith_res)
    );

    swod_rank #(
        .WINDOW_MAX (WINDOW_MAX),
        .CW         (CW),
        .AW         (AW)
    ) u_rank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (r_state == S_UPD),
        .i_wr_addr (full ? r_slot : r_held[AW-1:0]),
        .i_wr_data (r_x),
        .i_rd_addr (r_slot),
        .o_rd_data (old_val),
        .i_ctl     (rank_ctl),
        .i_med2    (r_med2),
        .i_count   (r_held),
        .o_done    (rank_done),
        .o_lo      (rank_lo),
        .o_hi      (rank_hi),
        .o_q1      (rank_q1),
        .o_q3      (rank_q3)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= WINDOW_LENGTH_RST;
            r_zt    <= Z_THR_RST;
            r_mzt   <= MODZ_THR_RST;
            r_im    <= IQR_MULT_RST;
            r_slot  <= '0;
            r_held  <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_WINDOW_LENGTH: begin
                        r_len  <= pwdata[LEN_W-1:0];
                        r_slot <= '0;
                        r_held <= '0;
                        r_sum  <= '0;
                        r_sq   <= '0;
                    end
                    REG_Z_THRESHOLD:    r_zt  <= pwdata[THR_W-1:0];
                    REG_MODZ_THRESHOLD: r_mzt <= pwdata[THR_W-1:0];
                    REG_IQR_MULT:       r_im  <= pwdata[THR_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_smp.valid) begin
                        r_x     <= i_smp.sample;
                        r_state <= S_RDOLD;
                    end
                end
                S_RDOLD: r_state <= S_UPD;
                S_UPD: begin
                    if (full) begin
                        r_sum  <= r_sum + SUM_W'(r_x) - SUM_W'(old_val);
                        r_sq   <= r_sq + SQ_W'($unsigned(x_sq)) - SQ_W'($unsigned(old_sq));
                        r_slot <= (AW'(r_slot + 1'b1) == AW'(eff_len) ||
                                   CW'(r_slot) + 1'b1 == eff_len) ? '0 : r_slot + 1'b1;
                    end else begin
                        r_sum  <= r_sum + SUM_W'(r_x);
                        r_sq   <= r_sq + SQ_W'($unsigned(x_sq));
                        r_held <= r_held + 1'b1;
                    end
                    r_state <= S_PROD1;
                end
                S_PROD1: begin
                    r_nsq   <= P_W'(r_held * r_sq);
                    r_s2    <= S2_W'(sum_mag * sum_mag);
                    r_nn    <= DEN_W'(r_held * r_held);
                    r_std   <= '0;
                    r_zf    <= 1'b0;
                    r_mzf   <= 1'b0;
                    r_iqf   <= 1'b0;
                    r_state <= S_MEAN;
                end
                S_MEAN: begin
                    if (arith_done) begin
                        r_mean <= r_sum[SUM_W-1]
                                  ? -$signed({1'b0, arith_res[MF_W-2:0]})
                                  : $signed({1'b0, arith_res[MF_W-2:0]});
                        r_state <= (r_held < CW'(STAT_MIN_COUNT)) ? S_OUT : S_VAR;
                    end
                end
                S_VAR:   r_state <= S_VWAIT;
                S_VWAIT: begin
                    if (arith_done) r_state <= S_SQRT;
                end
                S_SQRT:  r_state <= S_SWAIT;
                S_SWAIT: begin
                    if (arith_done) begin
                        r_std   <= (|root[RT_W-1:STD_W]) ? '1 : root[STD_W-1:0];
                        r_state <= S_RK0;
                    end
                end
                S_RK0:   r_state <= S_RK0W;
                S_RK0W: begin
                    if (rank_done) begin
                        r_med2  <= $signed({rank_lo[SAMPLE_W-1], rank_lo[SAMPLE_W-1:0]})
                                 + $signed({rank_hi[SAMPLE_W-1], rank_hi[SAMPLE_W-1:0]});
                        r_q1    <= rank_q1[SAMPLE_W-1:0];
                        r_q3    <= rank_q3[SAMPLE_W-1:0];
                        r_state <= S_RK1;
                    end
                end
                S_RK1:   r_state <= S_RK1W;
                S_RK1W: begin
                    if (rank_done) begin
                        r_mad4  <= $unsigned(rank_lo) + $unsigned(rank_hi);
                        r_state <= S_PROD2;
                    end
                end
                S_PROD2: begin
                    r_zl    <= {dz_abs, 8'd0};
                    r_zr    <= r_zt * r_std;
                    r_ml    <= dev4 * MODZ_CONST;
                    r_mr    <= r_mzt * r_mad4;
                    r_span  <= r_im * q_span;
                    r_state <= S_FLAG;
                end
                S_FLAG: begin
                    r_zf    <= CMP_W'(r_zl) > CMP_W'(r_zr);
                    r_mzf   <= CMP_W'(r_ml) > CMP_W'({r_mr, 8'd0});
                    r_iqf   <= (r_held >= CW'(IQR_MIN_COUNT)) &&
                               ((x8 < lo_fence) || (x8 > hi_fence));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_res.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_smp.ready         = (r_state == S_IDLE);
    assign o_res.valid         = (r_state == S_OUT);
    assign o_res.mean_q8       = r_mean[MEAN_W-1:0];
    assign o_res.std_dev_q8    = r_std;
    assign o_res.z_outlier     = r_zf;
    assign o_res.mod_z_outlier = r_mzf;
    assign o_res.iqr_outlier   = r_iqf;
    assign o_res.sample_count  = LEN_W'(r_held);

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_smp.ready)
        else $error("sample taken while a result word is pending");

    a_held_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held <= eff_len) && (CW'(r_slot) < eff_len))
        else $error("window fill or write slot beyond window length");

    a_rank_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rank_done |-> (r_state == S_RK0W || r_state == S_RK1W))
        else $error("rank pass finished outside a rank wait");

    a_arith_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        arith_done |-> (r_state == S_MEAN || r_state == S_VWAIT || r_state == S_SWAIT))
        else $error("shift-subtract unit finished outside a wait");
`endif

endmodule

// ===== tb/sv/tb_sliding_window_outlier_detector.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding-window outlier detector testbench
// Streams signed samples through the detector under several window lengths
// and threshold settings, predicts mean, deviation and the three outlier
// flags for every word, and checks each result word field by field.
// ----------------------------------------------------------------------------
module tb_sliding_window_outlier_detector;
    import swod_pkg::*;

    localparam int WIN_MAX    = 64;
    localparam int CYCLE_CAP  = 12_000_000;
    localparam int HOLD_LEN   = 3000;

    typedef struct {
        logic signed [MEAN_W-1:0] mean_q8;
        logic [STD_W-1:0]         std_dev_q8;
        logic                     z_outlier;
        logic                     mod_z_outlier;
        logic                     iqr_outlier;
        logic [LEN_W-1:0]         sample_count;
    } t_stats_word;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    swod_in_if  smp_if();
    swod_out_if res_if();

    sliding_window_outlier_detector DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    longint              win_vals [WIN_MAX];
    int unsigned         win_slot;
    int unsigned         win_held;
    longint              win_sum;
    longint              win_sqsum;
    logic [LEN_W-1:0]    cfg_len;
    logic [THR_W-1:0]    cfg_z;
    logic [THR_W-1:0]    cfg_modz;
    logic [THR_W-1:0]    cfg_iqr;

    logic signed [SAMPLE_W-1:0] sample_backlog [$];
    t_stats_word                stats_due [$];

    int  snd_idle_pct;
    int  rcv_idle_pct;
    int  hold_trig;
    int  hold_seen;
    int  hold_left;
    int  err_count;
    int  words_checked;
    int  z_hits, modz_hits, iqr_hits;
    longint cycles;
    bit  take;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    function automatic void queue_sample(input logic signed [SAMPLE_W-1:0] s);
        sample_backlog.insert(sample_backlog.size(), s);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void sort_list(ref longint a [WIN_MAX], input int unsigned n);
        longint v;
        int j;
        for (int i = 1; i < n; i++) begin
            v = a[i];
            j = i;
            while (j > 0 && a[j-1] > v) begin
                a[j] = a[j-1];
                j--;
            end
            a[j] = v;
        end
    endfunction

    function automatic longint middle_x2(ref longint a [WIN_MAX], input int unsigned n);
        if (n % 2) return 2 * a[n/2];
        return a[n/2 - 1] + a[n/2];
    endfunction

    function automatic t_stats_word window_stats(input logic signed [SAMPLE_W-1:0] s);
        t_stats_word w;
        int unsigned len, n, sl;
        longint x, old, mean, d, sd, med2, mad4, dev4, q1, q3, span;
        longint unsigned dd, nn, v, sdev, dev;
        longint srt [WIN_MAX];
        longint dvs [WIN_MAX];
        len = (cfg_len == 0) ? 1 : (cfg_len > WIN_MAX) ? WIN_MAX : cfg_len;
        x = s;
        if (win_held < len) begin
            win_vals[win_held] = x;
            win_held++;
        end else begin
            sl = win_slot % len;
            old = win_vals[sl];
            win_sum -= old;
            win_sqsum -= old * old;
            win_vals[sl] = x;
            win_slot = (sl + 1) % len;
        end
        win_sum += x;
        win_sqsum += x * x;
        n = win_held;
        mean = (n > 0) ? (win_sum * 256) / longint'(n) : 0;
        w.mean_q8 = mean[MEAN_W-1:0];
        w.std_dev_q8 = '0;
        w.z_outlier = 0;
        w.mod_z_outlier = 0;
        w.iqr_outlier = 0;
        w.sample_count = n[LEN_W-1:0];
        if (n >= 2) begin
            d = longint'(n) * win_sqsum - win_sum * win_sum;
            dd = (d < 0) ? 0 : d;
            nn = n * n;
            v = (dd / nn) * 65536 + ((dd % nn) * 65536) / nn;
            sdev = int_sqrt(v);
            if (sdev > 64'hFFFFFF) sdev = 64'hFFFFFF;
            w.std_dev_q8 = sdev[STD_W-1:0];
            sd = x * 256 - mean;
            dev = (sd < 0) ? -sd : sd;
            w.z_outlier = (dev * 256 > cfg_z * sdev);
            for (int i = 0; i < n; i++) srt[i] = win_vals[i];
            sort_list(srt, n);
            med2 = middle_x2(srt, n);
            for (int i = 0; i < n; i++) begin
                dvs[i] = 2 * srt[i] - med2;
                if (dvs[i] < 0) dvs[i] = -dvs[i];
            end
            sort_list(dvs, n);
            mad4 = middle_x2(dvs, n);
            dev4 = 2 * x - med2;
            if (dev4 < 0) dev4 = -dev4;
            dev4 *= 2;
            w.mod_z_outlier = (longint'(dev4) * longint'(MODZ_CONST)
                               > longint'(cfg_modz) * mad4 * 256);
            if (n >= IQR_MIN_COUNT) begin
                q1 = srt[n/4];
                q3 = srt[(3*n)/4];
                span = longint'(cfg_iqr) * (q3 - q1);
                w.iqr_outlier = (x * 256 < q1 * 256 - span) || (x * 256 > q3 * 256 + span);
            end
        end
        return w;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch on word %0d: %s got %0d want %0d", words_checked, field, got, want);
        err_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid <= 0;
            smp_if.sample <= '0;
        end else begin
            take = smp_if.valid && smp_if.ready;
            if (take) begin
                stats_due.insert(stats_due.size(), window_stats(sample_backlog.pop_front()));
            end
            if (smp_if.valid && !take) begin
                smp_if.valid <= 1;
            end else if (sample_backlog.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                smp_if.valid <= 1;
                smp_if.sample <= sample_backlog[0];
            end else begin
                smp_if.valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (stats_due.size() == 0) begin
                    $display("unexpected result word");
                    err_count++;
                end else begin
                    t_stats_word e;
                    e = stats_due.pop_front();
                    if (res_if.mean_q8 !== e.mean_q8)
                        report_mismatch("mean_q8", res_if.mean_q8, e.mean_q8);
                    if (res_if.std_dev_q8 !== e.std_dev_q8)
                        report_mismatch("std_dev_q8", res_if.std_dev_q8, e.std_dev_q8);
                    if (res_if.z_outlier !== e.z_outlier)
                        report_mismatch("z_outlier", res_if.z_outlier, e.z_outlier);
                    if (res_if.mod_z_outlier !== e.mod_z_outlier)
                        report_mismatch("mod_z_outlier", res_if.mod_z_outlier, e.mod_z_outlier);
                    if (res_if.iqr_outlier !== e.iqr_outlier)
                        report_mismatch("iqr_outlier", res_if.iqr_outlier, e.iqr_outlier);
                    if (res_if.sample_count !== e.sample_count)
                        report_mismatch("sample_count", res_if.sample_count, e.sample_count);
                    z_hits += e.z_outlier;
                    modz_hits += e.mod_z_outlier;
                    iqr_hits += e.iqr_outlier;
                end
                words_checked++;
            end
            if (hold_trig != hold_seen) begin
                hold_seen = hold_trig;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    task automatic reg_write(input t_reg_idx idx, input logic [APB_DATA_W-1:0] val);
        @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= APB_ADDR_W'(4 * int'(idx));
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_WINDOW_LENGTH: begin
                cfg_len = val[LEN_W-1:0];
                win_slot = 0;
                win_held = 0;
                win_sum = 0;
                win_sqsum = 0;
            end
            REG_Z_THRESHOLD:    cfg_z = val[THR_W-1:0];
            REG_MODZ_THRESHOLD: cfg_modz = val[THR_W-1:0];
            REG_IQR_MULT:       cfg_iqr = val[THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (sample_backlog.size() > 0 || stats_due.size() > 0 || smp_if.valid)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] next_sample(input int base);
        int m;
        m = $urandom_range(0, 9);
        case (m)
            0:       return SAMPLE_W'($urandom);
            1:       return SAMPLE_W'(base + $urandom_range(0, 4000) - 2000);
            2:       return ($urandom_range(0, 1)) ? 16'sh7FFF : -16'sh8000;
            3:       return SAMPLE_W'(base);
            default: return SAMPLE_W'(base + $urandom_range(0, 60) - 30);
        endcase
    endfunction

    initial begin
        int base, len, nitems;
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        smp_if.valid = 0; smp_if.sample = '0; res_if.ready = 0;
        cycles = 0; err_count = 0; words_checked = 0;
        z_hits = 0; modz_hits = 0; iqr_hits = 0;
        hold_trig = 0; hold_seen = 0; hold_left = 0;
        snd_idle_pct = 22; rcv_idle_pct = 56;
        cfg_len = WINDOW_LENGTH_RST; cfg_z = Z_THR_RST;
        cfg_modz = MODZ_THR_RST; cfg_iqr = IQR_MULT_RST;
        win_slot = 0; win_held = 0; win_sum = 0; win_sqsum = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: field extremes, flat window, spikes under reset settings
        queue_sample(16'sh7FFF);
        queue_sample(-16'sh8000);
        queue_sample(16'sh0000);
        queue_sample(16'sh0000);
        queue_sample(-16'sh0001);
        repeat (6) queue_sample(16'sd100);
        queue_sample(16'sd100);
        queue_sample(16'sd900);
        queue_sample(16'sh5555);
        queue_sample(-16'sh2AAB);
        queue_sample(16'sd100);
        drain();
        reg_write(REG_WINDOW_LENGTH, 0);
        queue_sample(16'sd7);
        queue_sample(-16'sd7);
        drain();
        reg_write(REG_WINDOW_LENGTH, 4);
        repeat (3) queue_sample(-16'sd50);
        queue_sample(-16'sd50);
        queue_sample(16'sd3000);
        drain();

        for (int p = 0; p < 24; p++) begin
            if (p == 8) begin snd_idle_pct = 56; rcv_idle_pct = 22; end
            if (p == 16) begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            len = (p == 5) ? 127 : (p == 12) ? 1 : $urandom_range(2, 10);
            reg_write(REG_WINDOW_LENGTH, len);
            case (p % 4)
                1: begin
                    reg_write(REG_Z_THRESHOLD, 0);
                    reg_write(REG_MODZ_THRESHOLD, 0);
                    reg_write(REG_IQR_MULT, 0);
                end
                2: begin
                    reg_write(REG_Z_THRESHOLD, 4095);
                    reg_write(REG_MODZ_THRESHOLD, 4095);
                    reg_write(REG_IQR_MULT, 4095);
                end
                default: begin
                    reg_write(REG_Z_THRESHOLD, $urandom_range(0, 1200));
                    reg_write(REG_MODZ_THRESHOLD, $urandom_range(0, 1200));
                    reg_write(REG_IQR_MULT, $urandom_range(0, 800));
                end
            endcase
            base = $urandom_range(0, 60000) - 30000;
            nitems = (p == 5) ? 72 : 70;
            for (int i = 0; i < nitems; i++) begin
                queue_sample(next_sample(base));
                if (p == 10 && i == nitems / 2) drain();
            end
            if (p == 3) hold_trig++;
            drain();
        end

        repeat (50) @(posedge i_clk);
        $display("checked %0d result words over many window lengths and thresholds", words_checked);
        $display("flags raised: z %0d, modified z %0d, iqr %0d", z_hits, modz_hits, iqr_hits);
        if (err_count == 0 && stats_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/swod_pkg.sv
hw/rtl/swod_if.sv
hw/rtl/swod_arith.sv
hw/rtl/swod_rank.sv
hw/rtl/sliding_window_outlier_detector.sv
tb/sv/tb_sliding_window_outlier_detector.sv
